@@ rtl/lu8_pkg.sv @@
`timescale 1ns / 1ps

package lu8_pkg;

    // Input transfer: one text byte and its end-of-text flag.
    typedef struct packed {
        logic [7:0] text_byte;
        logic       final_byte;
    } byte_item_t;

    // Output transfer: one decoded code point.
    typedef struct packed {
        logic [20:0] code_point;
        logic        run_last;
        logic        text_end;
    } cp_item_t;

    // Command kinds passed from the front to the back.
    typedef enum logic {
        CMD_PLAIN,   // one result: zero, a literal byte or an assembled sequence
        CMD_TRUNC    // text ended inside a sequence: zero, then re-decode the tail
    } cmd_op_t;

    typedef struct packed {
        cmd_op_t         op;
        logic [3:0][7:0] seq_bytes;   // element 0 is the first byte
        logic [2:0]      len;         // plain: 0 invalid, 1 literal, 2..4 sequence;
                                      // trunc: tail byte count, 1 or 2
        logic            fin;
    } cmd_t;

    localparam int unsigned QueueDepth = 2;

    localparam logic [2:0] LenInvalid = 3'd0;
    localparam logic [2:0] LenAscii   = 3'd1;
    localparam logic [2:0] LenTwo     = 3'd2;
    localparam logic [2:0] LenThree   = 3'd3;
    localparam logic [2:0] LenFour    = 3'd4;

    // Sequence length announced by a byte: 1 for ASCII, 2..4 for a lead,
    // 0 for a byte that cannot start a sequence.
    function automatic logic [2:0] lead_length(input logic [7:0] c);
        logic [2:0] len;
        begin
            if (c[7] == 1'b0) begin
                len = LenAscii;
            end else if ((c & 8'hE0) == 8'hC0) begin
                len = LenTwo;
            end else if ((c & 8'hF0) == 8'hE0) begin
                len = LenThree;
            end else if ((c & 8'hF8) == 8'hF0) begin
                len = LenFour;
            end else begin
                len = LenInvalid;
            end
            return len;
        end
    endfunction

    // Build the code point of a complete sequence of 2..4 bytes.
    function automatic logic [20:0] assemble(input logic [3:0][7:0] b,
                                             input logic [2:0] len);
        logic [20:0] cp;
        begin
            unique case (len)
                LenTwo:   cp = {10'd0, b[0][4:0], b[1][5:0]};
                LenThree: cp = {5'd0, b[0][3:0], b[1][5:0], b[2][5:0]};
                LenFour:  cp = {b[0][2:0], b[1][5:0], b[2][5:0], b[3][5:0]};
                default:  cp = 21'd0;
            endcase
            return cp;
        end
    endfunction

endpackage

@@ rtl/lu8_front.sv @@
`timescale 1ns / 1ps

module lu8_front (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                accept,
    input  lu8_pkg::byte_item_t item,
    output logic                push,
    output lu8_pkg::cmd_t       cmd
);

    logic [2:0]      seq_len_reg, seq_len_next;
    logic [1:0]      pend_cnt_reg, pend_cnt_next;
    logic [2:0][7:0] pend_reg, pend_next;

    logic [7:0] c;
    logic       fin;
    logic [2:0] lead;
    logic [3:0][7:0] full_seq;

    assign c    = item.text_byte;
    assign fin  = item.final_byte;
    assign lead = lu8_pkg::lead_length(c);

    // Buffered bytes with the incoming byte placed right after them.
    always_comb
    begin
        full_seq = {c, pend_reg};
        case (pend_cnt_reg)
            2'd1:    full_seq[1] = c;
            2'd2:    full_seq[2] = c;
            default: full_seq[3] = c;
        endcase
    end

    always_comb
    begin
        seq_len_next  = seq_len_reg;
        pend_cnt_next = pend_cnt_reg;
        pend_next     = pend_reg;
        push          = 1'b0;
        cmd.op        = lu8_pkg::CMD_PLAIN;
        cmd.seq_bytes = {8'd0, 8'd0, 8'd0, c};
        cmd.len       = lu8_pkg::LenInvalid;
        cmd.fin       = fin;

        if (accept) begin
            if (seq_len_reg == lu8_pkg::LenInvalid) begin
                if (lead == lu8_pkg::LenAscii) begin
                    push    = 1'b1;
                    cmd.len = lu8_pkg::LenAscii;
                end else if (lead == lu8_pkg::LenInvalid || fin) begin
                    push = 1'b1;
                end else begin
                    pend_next[0]  = c;
                    pend_cnt_next = 2'd1;
                    seq_len_next  = lead;
                end
            end else if (({1'b0, pend_cnt_reg} + 3'd1) == seq_len_reg) begin
                // Sequence complete
                push          = 1'b1;
                cmd.seq_bytes = full_seq;
                cmd.len       = seq_len_reg;
                pend_cnt_next = 2'd0;
                seq_len_next  = lu8_pkg::LenInvalid;
            end else if (!fin) begin
                case (pend_cnt_reg)
                    2'd1:    pend_next[1] = c;
                    default: pend_next[2] = c;
                endcase
                pend_cnt_next = pend_cnt_reg + 2'd1;
            end else begin
                // Text ends mid-sequence: hand the tail over for re-decode
                push   = 1'b1;
                cmd.op = lu8_pkg::CMD_TRUNC;
                if (pend_cnt_reg == 2'd1) begin
                    cmd.seq_bytes = {8'd0, 8'd0, 8'd0, c};
                    cmd.len       = 3'd1;
                end else begin
                    cmd.seq_bytes = {8'd0, 8'd0, c, pend_reg[1]};
                    cmd.len       = 3'd2;
                end
                pend_cnt_next = 2'd0;
                seq_len_next  = lu8_pkg::LenInvalid;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            seq_len_reg  <= lu8_pkg::LenInvalid;
            pend_cnt_reg <= 2'd0;
        end else begin
            seq_len_reg  <= seq_len_next;
            pend_cnt_reg <= pend_cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pend_reg <= pend_next;
    end

endmodule

@@ rtl/lu8_queue.sv @@
`timescale 1ns / 1ps

module lu8_queue (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  lu8_pkg::cmd_t push_cmd,
    input  logic          pop,
    output logic          full,
    output logic          head_valid,
    output lu8_pkg::cmd_t head_cmd
);

    localparam int unsigned PtrW = $clog2(lu8_pkg::QueueDepth);
    localparam int unsigned CntW = $clog2(lu8_pkg::QueueDepth + 1);

    lu8_pkg::cmd_t slot_reg [lu8_pkg::QueueDepth];
    logic [PtrW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PtrW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CntW-1:0] count_reg, count_next;
    logic            do_push, do_pop;

    assign full       = (count_reg == CntW'(lu8_pkg::QueueDepth));
    assign head_valid = (count_reg != '0);
    assign head_cmd   = slot_reg[rd_ptr_reg];
    assign do_push    = push && !full;
    assign do_pop     = pop && head_valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == PtrW'(lu8_pkg::QueueDepth - 1)) ? '0
                          : wr_ptr_reg + PtrW'(1);
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == PtrW'(lu8_pkg::QueueDepth - 1)) ? '0
                          : rd_ptr_reg + PtrW'(1);
        end
        count_next = count_reg + CntW'(do_push) - CntW'(do_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push) begin
            slot_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

@@ rtl/lu8_back.sv @@
`timescale 1ns / 1ps

module lu8_back (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                head_valid,
    input  lu8_pkg::cmd_t       head_cmd,
    output logic                pop,
    output logic                cp_valid,
    input  logic                cp_stall,
    output lu8_pkg::cp_item_t   cp_data
);

    logic [1:0]  idx_reg, idx_next;
    logic        out_valid_reg, out_valid_next;
    lu8_pkg::cp_item_t out_reg, out_next;

    logic [1:0]  n_res;
    logic [2:0][20:0] cps;
    logic [20:0] cp_sel;
    logic        load, last;
    logic [7:0]  t0, t1;
    logic [2:0]  len0, len1;

    assign t0   = head_cmd.seq_bytes[0];
    assign t1   = head_cmd.seq_bytes[1];
    assign len0 = lu8_pkg::lead_length(t0);
    assign len1 = lu8_pkg::lead_length(t1);

    // Expand the head command into its list of results.
    always_comb
    begin
        n_res = 2'd1;
        cps   = '0;
        if (head_cmd.op == lu8_pkg::CMD_PLAIN) begin
            case (head_cmd.len)
                lu8_pkg::LenInvalid: cps[0] = 21'd0;
                lu8_pkg::LenAscii:   cps[0] = {13'd0, t0};
                default:             cps[0] = lu8_pkg::assemble(head_cmd.seq_bytes,
                                                                head_cmd.len);
            endcase
        end else if (head_cmd.len == 3'd1) begin
            n_res  = 2'd2;
            cps[1] = (len0 == lu8_pkg::LenAscii) ? {13'd0, t0} : 21'd0;
        end else if (len0 == lu8_pkg::LenTwo) begin
            n_res  = 2'd2;
            cps[1] = lu8_pkg::assemble(head_cmd.seq_bytes, lu8_pkg::LenTwo);
        end else begin
            n_res  = 2'd3;
            cps[1] = (len0 == lu8_pkg::LenAscii) ? {13'd0, t0} : 21'd0;
            cps[2] = (len1 == lu8_pkg::LenAscii) ? {13'd0, t1} : 21'd0;
        end
    end

    always_comb
    begin
        case (idx_reg)
            2'd0:    cp_sel = cps[0];
            2'd1:    cp_sel = cps[1];
            default: cp_sel = cps[2];
        endcase
    end

    assign load = head_valid && (!out_valid_reg || !cp_stall);
    assign last = (idx_reg + 2'd1) == n_res;
    assign pop  = load && last;

    always_comb
    begin
        idx_next       = idx_reg;
        out_valid_next = out_valid_reg;
        out_next       = out_reg;
        if (load) begin
            out_valid_next      = 1'b1;
            out_next.code_point = cp_sel;
            out_next.run_last   = last;
            out_next.text_end   = last && head_cmd.fin;
            idx_next            = last ? 2'd0 : idx_reg + 2'd1;
        end else if (!cp_stall) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            idx_reg       <= 2'd0;
            out_valid_reg <= 1'b0;
        end else begin
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
    end

    assign cp_valid = out_valid_reg;
    assign cp_data  = out_reg;

endmodule

@@ rtl/lenient_utf8_codepoint_decoder_core.sv @@
`timescale 1ns / 1ps

// Channel  | Handshake             | Payload                                        | Dir
// ---------+-----------------------+------------------------------------------------+----
// byte     | byte_valid/byte_stall | byte_data: text_byte[8], final_byte            | in
// cp       | cp_valid/cp_stall     | cp_data: code_point[21], run_last, text_end    | out
//
// One byte transfer per cycle while byte_stall is low; a byte yields zero or one result, except
// a final byte that leaves a sequence open, which yields two or three, drained one per cycle
// while cp_stall is low. The queue entry is written at the byte transfer edge and the output
// register loads from the queue head once it is free to take a new result.
// Reset clears the sequence state, the queue and the output valid. byte_stall
// rises only when the two-entry queue is full: under cp_stall or a multi-result drain.

module lenient_utf8_codepoint_decoder_core (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                byte_valid,
    output logic                byte_stall,
    input  lu8_pkg::byte_item_t byte_data,
    output logic                cp_valid,
    input  logic                cp_stall,
    output lu8_pkg::cp_item_t   cp_data
);

    logic          accept;
    logic          push;
    lu8_pkg::cmd_t push_cmd;
    logic          full;
    logic          head_valid;
    lu8_pkg::cmd_t head_cmd;
    logic          pop;

    // Take a byte whenever the queue has room; buffered bytes push nothing.
    assign byte_stall = full;
    assign accept     = byte_valid && !full;

    // Front: track the open sequence and classify each byte into a command.
    lu8_front u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .accept (accept),
        .item   (byte_data),
        .push   (push),
        .cmd    (push_cmd)
    );

    // Queue: decouple classification from result generation.
    lu8_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_cmd   (push_cmd),
        .pop        (pop),
        .full       (full),
        .head_valid (head_valid),
        .head_cmd   (head_cmd)
    );

    // Back: expand each command into results and hold them in the output register.
    lu8_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head_cmd   (head_cmd),
        .pop        (pop),
        .cp_valid   (cp_valid),
        .cp_stall   (cp_stall),
        .cp_data    (cp_data)
    );

endmodule

@@ tb/sv/lenient_utf8_codepoint_decoder_core_test.sv @@
`timescale 1ns / 1ps

module lenient_utf8_codepoint_decoder_core_test;

    import lu8_pkg::*;

    logic       clk;
    logic       rst_n = 1'b0;
    logic       byte_valid = 1'b0;
    logic       byte_stall;
    byte_item_t byte_data = '0;
    logic       cp_valid;
    logic       cp_stall = 1'b0;
    cp_item_t   cp_data;

    lenient_utf8_codepoint_decoder_core uut (
        .clk        (clk),
        .rst_n      (rst_n),
        .byte_valid (byte_valid),
        .byte_stall (byte_stall),
        .byte_data  (byte_data),
        .cp_valid   (cp_valid),
        .cp_stall   (cp_stall),
        .cp_data    (cp_data)
    );

    // Decoder state as the block should hold it: the open lead plus any
    // buffered following bytes, and the length the lead announced.
    logic [7:0]  held_bytes [0:2] = '{8'h00, 8'h00, 8'h00};
    int unsigned held_count = 0;
    int unsigned open_length = 0;

    // Code points still owed by the block, oldest first.
    cp_item_t    predicted_cps [$];

    int unsigned mismatch_count = 0;
    int unsigned bytes_sent = 0;

    // When set, neither side inserts bubbles.
    bit          steady = 1'b0;

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Generous wall against a hung run.
    initial
    begin
        #4_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

    // Length a byte announces when it shows up outside a sequence.
    function automatic logic [2:0] byte_class(input logic [7:0] c);
        if (!c[7])
            return LenAscii;
        if (c[7:5] == 3'b110)
            return LenTwo;
        if (c[7:4] == 4'b1110)
            return LenThree;
        if (c[7:3] == 5'b11110)
            return LenFour;
        return LenInvalid;
    endfunction

    // Fold a complete sequence; byte i sits in bits [8*i +: 8].
    function automatic logic [20:0] fold_sequence(input logic [31:0] s, input logic [2:0] n);
        logic [20:0] cp;
        int unsigned i;
        if (n == LenTwo)
            cp = 21'(s[4:0]);
        else if (n == LenThree)
            cp = 21'(s[3:0]);
        else
            cp = 21'(s[2:0]);
        for (i = 1; i < n; i++)
            cp = (cp << 6) | 21'(s[8*i +: 6]);
        return cp;
    endfunction

    // Advance the expected decoder state by one byte and queue every code
    // point that byte should release.
    function automatic void decode_byte(input logic [7:0] c, input logic fin);
        logic [20:0] found [$];
        logic [31:0] seq;
        logic [2:0]  len;
        cp_item_t    item;
        int unsigned k;
        int unsigned tail_len;
        if (open_length == 0) begin
            len = byte_class(c);
            if (len == LenAscii) begin
                found = {found, 21'(c)};
            end
            else if (len == LenInvalid || fin) begin
                found = {found, 21'd0};
            end
            else begin
                held_bytes[0] = c;
                held_count = 1;
                open_length = len;
            end
        end
        else if (held_count + 1 >= open_length) begin
            // Sequence complete: following bytes are taken as they are.
            seq = '0;
            for (k = 0; k < held_count; k++)
                seq[8*k +: 8] = held_bytes[k];
            seq[8*held_count +: 8] = c;
            found = {found, fold_sequence(seq, 3'(held_count + 1))};
            held_count = 0;
            open_length = 0;
        end
        else if (!fin) begin
            // Quiet step: buffer and wait for more.
            held_bytes[held_count] = c;
            held_count++;
        end
        else begin
            // Text ended inside a sequence: the lead yields zero, then the
            // tail after the lead is decoded again from its first byte.
            found = {found, 21'd0};
            seq = '0;
            tail_len = 0;
            for (k = 1; k < held_count; k++) begin
                seq[8*tail_len +: 8] = held_bytes[k];
                tail_len++;
            end
            seq[8*tail_len +: 8] = c;
            tail_len++;
            k = 0;
            while (k < tail_len && found.size() < 3) begin
                len = byte_class(seq[8*k +: 8]);
                if (len == LenAscii) begin
                    found = {found, 21'(seq[8*k +: 8])};
                    k++;
                end
                else if (len != LenInvalid && k + len <= tail_len) begin
                    found = {found, fold_sequence(seq >> (8*k), len)};
                    k += len;
                end
                else begin
                    found = {found, 21'd0};
                    k++;
                end
            end
            held_count = 0;
            open_length = 0;
        end
        for (k = 0; k < found.size(); k++) begin
            item.code_point = found[k];
            item.run_last = (k == found.size() - 1);
            item.text_end = fin && (k == found.size() - 1);
            predicted_cps = {predicted_cps, item};
        end
    endfunction

    // Receiver back-pressure: stall at random, about a fifth of the time.
    always @(posedge clk)
    begin
        cp_stall <= !steady && ($urandom_range(99) < 21);
    end

    // Score every result transfer against the oldest prediction.
    always @(posedge clk)
    begin : score_results
        cp_item_t want;
        if (rst_n && cp_valid && !cp_stall) begin
            if (predicted_cps.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("unexpected result: code_point %h run_last %b text_end %b",
                             cp_data.code_point, cp_data.run_last, cp_data.text_end);
            end
            else begin
                want = predicted_cps.pop_front();
                if (cp_data.code_point !== want.code_point
                        || cp_data.run_last !== want.run_last
                        || cp_data.text_end !== want.text_end) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("mismatch: expected cp %h last %b end %b, got cp %h last %b end %b",
                                 want.code_point, want.run_last, want.text_end,
                                 cp_data.code_point, cp_data.run_last, cp_data.text_end);
                end
            end
        end
    end

    // Offer one byte, with a random bubble first, and hold it until taken.
    // Valid stays high after the transfer so back-to-back bytes need no gap.
    task automatic send_byte(input logic [7:0] c, input logic fin);
        if (!steady) begin
            while ($urandom_range(99) < 21) begin
                byte_valid <= 1'b0;
                @(posedge clk);
            end
        end
        byte_valid <= 1'b1;
        byte_data <= '{text_byte: c, final_byte: fin};
        @(posedge clk);
        while (byte_stall)
            @(posedge clk);
        decode_byte(c, fin);
        bytes_sent++;
    endtask

    // Hold off the sender until the block has returned every result owed.
    task automatic drain_results();
        byte_valid <= 1'b0;
        do
            @(posedge clk);
        while (predicted_cps.size() != 0);
    endtask

    function automatic logic [7:0] follow_byte();
        if ($urandom_range(9) == 0)
            return 8'($urandom_range(255));
        return 8'h80 | 8'($urandom_range(63));
    endfunction

    function automatic logic [7:0] lead_byte(input int unsigned len);
        case (len)
            1: return 8'($urandom_range(127));
            2: return 8'hC0 | 8'($urandom_range(31));
            3: return 8'hE0 | 8'($urandom_range(15));
            default: return 8'hF0 | 8'($urandom_range(7));
        endcase
    endfunction

    task automatic test_ascii_and_invalid();
        send_byte(8'h00, 1'b1);
        send_byte(8'h7F, 1'b0);
        send_byte(8'h80, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'hF8, 1'b1);
    endtask

    // Full sequences at the edges of each lead range; followers unchecked.
    task automatic test_complete_sequences();
        send_byte(8'hC0, 1'b0);
        send_byte(8'h80, 1'b0);
        send_byte(8'hDF, 1'b0);
        send_byte(8'h3F, 1'b0);
        send_byte(8'hEF, 1'b0);
        send_byte(8'hBF, 1'b0);
        send_byte(8'hBF, 1'b0);
        send_byte(8'hF7, 1'b0);
        send_byte(8'hBF, 1'b0);
        send_byte(8'hBF, 1'b0);
        send_byte(8'hFF, 1'b1);
    endtask

    // Lead on the last byte, and texts that stop inside a sequence so the
    // tail gets re-decoded: ASCII pair, an assembled pair, a lead too long
    // for what is left.
    task automatic test_truncated_texts();
        send_byte(8'hE5, 1'b1);
        send_byte(8'hF0, 1'b0);
        send_byte(8'h41, 1'b0);
        send_byte(8'h42, 1'b1);
        send_byte(8'hF0, 1'b0);
        send_byte(8'hC3, 1'b0);
        send_byte(8'hA9, 1'b1);
        send_byte(8'hF0, 1'b0);
        send_byte(8'hE0, 1'b0);
        send_byte(8'h80, 1'b1);
        drain_results();
    endtask

    // Build one text, mostly well-formed characters with random content;
    // some texts are raw noise and some stop inside a sequence.
    task automatic send_random_text();
        logic [7:0]  text [$];
        int unsigned chars;
        int unsigned shape;
        int unsigned len;
        int unsigned k;
        int unsigned j;
        chars = $urandom_range(1, 8);
        shape = $urandom_range(99);
        for (k = 0; k < chars; k++) begin
            if (shape < 12) begin
                text = {text, 8'($urandom_range(255))};
            end
            else if ($urandom_range(19) == 0) begin
                // stray byte that cannot open a sequence
                if ($urandom_range(1))
                    text = {text, 8'h80 | 8'($urandom_range(63))};
                else
                    text = {text, 8'hF8 | 8'($urandom_range(7))};
            end
            else begin
                len = $urandom_range(1, 4);
                text = {text, lead_byte(len)};
                for (j = 1; j < len; j++)
                    text = {text, follow_byte()};
            end
        end
        if (shape >= 70) begin
            // cut the text off inside a sequence
            len = $urandom_range(2, 4);
            text = {text, lead_byte(len)};
            for (j = $urandom_range(0, len - 2); j > 0; j--)
                text = {text, 8'($urandom_range(255))};
        end
        for (k = 0; k < text.size(); k++)
            send_byte(text[k], k == text.size() - 1);
    endtask

    task automatic test_random_texts();
        int unsigned first;
        int unsigned texts;
        first = bytes_sent;
        texts = 0;
        while (bytes_sent - first < 450) begin
            steady = (bytes_sent - first >= 150) && (bytes_sent - first < 260);
            send_random_text();
            texts++;
            if (texts % 40 == 0)
                drain_results();
        end
        steady = 1'b0;
    endtask

    initial
    begin
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_ascii_and_invalid();
        test_complete_sequences();
        test_truncated_texts();
        test_random_texts();

        // Let the last results land, then watch for strays.
        drain_results();
        repeat (10) @(posedge clk);
        if (mismatch_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
